@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/um_pkg.sv @@
// ----------------------------------------------------------------------------
// um_pkg
// types and constants of the register machine execute unit
// ----------------------------------------------------------------------------
package um_pkg;

    localparam int DATA_W     = 32;
    localparam int REG_CNT    = 8;
    localparam int REG_IDX_W  = 3;
    localparam int OPCODE_LSB = 28;
    localparam int OPCODE_W   = 4;
    localparam int LV_REG_LSB = 25;
    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CMOV  = 4'd0,
        OP_LOAD  = 4'd1,
        OP_STORE = 4'd2,
        OP_ADD   = 4'd3,
        OP_MUL   = 4'd4,
        OP_DIV   = 4'd5,
        OP_NAND  = 4'd6,
        OP_HALT  = 4'd7,
        OP_MAP   = 4'd8,
        OP_UNMAP = 4'd9,
        OP_OUT   = 4'd10,
        OP_IN    = 4'd11,
        OP_LDPRG = 4'd12,
        OP_LDVAL = 4'd13
    } op_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_OUT   = 3'd1,
        ACT_LOAD  = 3'd2,
        ACT_STORE = 3'd3,
        ACT_MAP   = 3'd4,
        ACT_UNMAP = 3'd5,
        ACT_LDPRG = 3'd6,
        ACT_HALT  = 3'd7
    } act_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_B,
        S_RD_C,
        S_RD_A,
        S_EXEC,
        S_ALU,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_MUL,
        ALU_DIV,
        ALU_NAND
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef struct packed {
        logic              req_type;
        logic [DATA_W-1:0] instr_word;
        logic [7:0]        in_byte;
        logic              in_eof;
        logic [DATA_W-1:0] resp_value;
    } in_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [DATA_W-1:0] segment_id;
        logic [DATA_W-1:0] seg_offset;
        logic [DATA_W-1:0] data_value;
        logic [7:0]        out_char;
        logic              jump_valid;
        logic [DATA_W-1:0] jump_target;
        logic              fault;
    } out_t;

endpackage

@@ rtl/um_ram.sv @@
// ----------------------------------------------------------------------------
// um_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module um_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/um_alu.sv @@
// ----------------------------------------------------------------------------
// um_alu
// shared arithmetic unit: one-step add and nand, 32-step multiply and divide
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module um_alu (
    input  logic                     clk,
    input  logic                     rst_n,
    input  um_pkg::alu_cmd_t         cmd,
    input  logic [um_pkg::DATA_W-1:0] opa,
    input  logic [um_pkg::DATA_W-1:0] opb,
    output um_pkg::alu_stat_t        stat,
    output logic [um_pkg::DATA_W-1:0] result
);

    localparam int W     = um_pkg::DATA_W;
    localparam int CNT_W = $clog2(W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    um_pkg::alu_op_t     op_reg, op_next;
    logic [W-1:0]        acc_reg, acc_next;
    logic [W-1:0]        b_reg, b_next;
    logic [W-1:0]        q_reg, q_next;

    logic [W:0]          add_x, add_y, sum;
    logic                add_cin;
    logic [W:0]          rem_sh;

    // one adder serves add, multiply and divide
    always_comb
    begin
        rem_sh = {acc_reg, q_reg[W-1]};
        if (busy_reg && op_reg == um_pkg::ALU_DIV)
        begin
            add_x   = rem_sh;
            add_y   = ~{1'b0, b_reg};
            add_cin = 1'b1;
        end
        else if (busy_reg)
        begin
            add_x   = {1'b0, acc_reg};
            add_y   = {1'b0, b_reg};
            add_cin = 1'b0;
        end
        else
        begin
            add_x   = {1'b0, opa};
            add_y   = {1'b0, opb};
            add_cin = 1'b0;
        end
        sum = add_x + add_y + (W+1)'(add_cin);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        q_next    = q_reg;
        if (cmd.start)
        begin
            op_next  = cmd.op;
            cnt_next = '0;
            unique case (cmd.op)
                um_pkg::ALU_ADD:
                begin
                    acc_next  = sum[W-1:0];
                    done_next = 1'b1;
                end
                um_pkg::ALU_NAND:
                begin
                    acc_next  = ~(opa & opb);
                    done_next = 1'b1;
                end
                um_pkg::ALU_MUL:
                begin
                    acc_next  = '0;
                    b_next    = opa;
                    q_next    = opb;
                    busy_next = 1'b1;
                end
                um_pkg::ALU_DIV:
                begin
                    acc_next  = '0;
                    b_next    = opb;
                    q_next    = opa;
                    busy_next = 1'b1;
                end
            endcase
        end
        else if (busy_reg)
        begin
            if (op_reg == um_pkg::ALU_DIV)
            begin
                // restoring step, sign of the trial difference picks the bit
                acc_next = sum[W] ? rem_sh[W-1:0] : sum[W-1:0];
                q_next   = {q_reg[W-2:0], ~sum[W]};
            end
            else
            begin
                if (q_reg[0])
                begin
                    acc_next = sum[W-1:0];
                end
                b_next = {b_reg[W-2:0], 1'b0};
                q_next = {1'b0, q_reg[W-1:1]};
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= um_pkg::ALU_ADD;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = (op_reg == um_pkg::ALU_DIV) ? q_reg : acc_reg;

    `ASSERT_IMP(a_no_start_busy, clk, rst_n, cmd.start, !busy_reg)
    `ASSERT_NXT(a_last_step_done, clk, rst_n, busy_reg && cnt_reg == CNT_W'(W-1), done_reg)
    `ASSERT_IMP(a_done_not_busy, clk, rst_n, done_reg, !busy_reg)

endmodule

@@ rtl/um_instruction_execute.sv @@
// ----------------------------------------------------------------------------
// steps: accept, read b, read c, read a, execute, alu wait for alu ops, done, output
// one transaction at a time, next accept only in idle once the result is registered
// mul and div run the 32-step loop of the shared alu adder
// reset: registers read as zero, pending load/map and output clear at once
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module um_instruction_execute (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  um_pkg::in_t  in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output um_pkg::out_t out_data
);

    localparam int W  = um_pkg::DATA_W;
    localparam int IW = um_pkg::REG_IDX_W;

    um_pkg::state_t           state_reg, state_next;
    um_pkg::in_t              item_reg, item_next;
    logic [W-1:0]             vb_reg, vb_next;
    logic [W-1:0]             vc_reg, vc_next;
    um_pkg::out_t             res_reg, res_next;
    um_pkg::out_t             out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;
    logic [um_pkg::REG_CNT-1:0] valid_reg, valid_next;
    logic [IW-1:0]            pend_dest_reg, pend_dest_next;
    logic                     pend_valid_reg, pend_valid_next;

    logic                     ram_we;
    logic [IW-1:0]            ram_waddr, ram_raddr;
    logic [W-1:0]             ram_wdata, ram_rdata;

    um_pkg::alu_cmd_t         alu_cmd;
    um_pkg::alu_stat_t        alu_stat;
    logic [W-1:0]             alu_result;

    logic [IW-1:0]            fa, fb, fc;
    logic [W-1:0]             rd_val, va;
    um_pkg::op_t              op;

    assign fa = item_reg.instr_word[8:6];
    assign fb = item_reg.instr_word[5:3];
    assign fc = item_reg.instr_word[2:0];
    assign op = um_pkg::op_t'(item_reg.instr_word[um_pkg::OPCODE_LSB +: um_pkg::OPCODE_W]);
    assign va = rd_val;

    um_ram #(
        .WIDTH (W),
        .DEPTH (um_pkg::REG_CNT)
    ) u_regs (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    um_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (alu_cmd),
        .opa    (vb_reg),
        .opb    (vc_reg),
        .stat   (alu_stat),
        .result (alu_result)
    );

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        vb_next         = vb_reg;
        vc_next         = vc_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        valid_next      = valid_reg;
        pend_dest_next  = pend_dest_reg;
        pend_valid_next = pend_valid_reg;
        ram_we          = 1'b0;
        ram_waddr       = fa;
        ram_wdata       = alu_result;
        ram_raddr       = fb;
        alu_cmd.start   = 1'b0;
        alu_cmd.op      = um_pkg::ALU_ADD;
        rd_val          = '0;

        unique case (state_reg)
            um_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next  = in_data;
                    state_next = um_pkg::S_RD_B;
                end
            end
            um_pkg::S_RD_B:
            begin
                ram_raddr  = fb;
                state_next = um_pkg::S_RD_C;
            end
            um_pkg::S_RD_C:
            begin
                ram_raddr  = fc;
                vb_next    = valid_reg[fb] ? ram_rdata : '0;
                state_next = um_pkg::S_RD_A;
            end
            um_pkg::S_RD_A:
            begin
                ram_raddr  = fa;
                vc_next    = valid_reg[fc] ? ram_rdata : '0;
                state_next = um_pkg::S_EXEC;
            end
            um_pkg::S_EXEC:
            begin
                rd_val     = valid_reg[fa] ? ram_rdata : '0;
                res_next   = '0;
                state_next = um_pkg::S_DONE;
                if (item_reg.req_type)
                begin
                    // memory response lands in the register the request named
                    if (pend_valid_reg)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = pend_dest_reg;
                        ram_wdata       = item_reg.resp_value;
                        pend_valid_next = 1'b0;
                    end
                end
                else
                begin
                    unique case (op)
                        um_pkg::OP_CMOV:
                        begin
                            ram_we    = (vc_reg != '0);
                            ram_wdata = vb_reg;
                        end
                        um_pkg::OP_LOAD:
                        begin
                            res_next.action     = um_pkg::ACT_LOAD;
                            res_next.segment_id = vb_reg;
                            res_next.seg_offset = vc_reg;
                            pend_dest_next      = fa;
                            pend_valid_next     = 1'b1;
                        end
                        um_pkg::OP_STORE:
                        begin
                            res_next.action     = um_pkg::ACT_STORE;
                            res_next.segment_id = va;
                            res_next.seg_offset = vb_reg;
                            res_next.data_value = vc_reg;
                        end
                        um_pkg::OP_ADD:
                        begin
                            alu_cmd.start = 1'b1;
                            alu_cmd.op    = um_pkg::ALU_ADD;
                            state_next    = um_pkg::S_ALU;
                        end
                        um_pkg::OP_MUL:
                        begin
                            alu_cmd.start = 1'b1;
                            alu_cmd.op    = um_pkg::ALU_MUL;
                            state_next    = um_pkg::S_ALU;
                        end
                        um_pkg::OP_DIV:
                        begin
                            if (vc_reg == '0)
                            begin
                                res_next.fault = 1'b1;
                            end
                            else
                            begin
                                alu_cmd.start = 1'b1;
                                alu_cmd.op    = um_pkg::ALU_DIV;
                                state_next    = um_pkg::S_ALU;
                            end
                        end
                        um_pkg::OP_NAND:
                        begin
                            alu_cmd.start = 1'b1;
                            alu_cmd.op    = um_pkg::ALU_NAND;
                            state_next    = um_pkg::S_ALU;
                        end
                        um_pkg::OP_HALT:
                        begin
                            res_next.action = um_pkg::ACT_HALT;
                        end
                        um_pkg::OP_MAP:
                        begin
                            res_next.action     = um_pkg::ACT_MAP;
                            res_next.data_value = vc_reg;
                            pend_dest_next      = fb;
                            pend_valid_next     = 1'b1;
                        end
                        um_pkg::OP_UNMAP:
                        begin
                            res_next.action     = um_pkg::ACT_UNMAP;
                            res_next.segment_id = vc_reg;
                        end
                        um_pkg::OP_OUT:
                        begin
                            res_next.action   = um_pkg::ACT_OUT;
                            res_next.out_char = vc_reg[7:0];
                        end
                        um_pkg::OP_IN:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = fc;
                            ram_wdata = item_reg.in_eof ? um_pkg::ALL_ONES
                                                        : W'(item_reg.in_byte);
                        end
                        um_pkg::OP_LDPRG:
                        begin
                            res_next.action      = um_pkg::ACT_LDPRG;
                            res_next.segment_id  = vb_reg;
                            res_next.jump_valid  = 1'b1;
                            res_next.jump_target = vc_reg;
                        end
                        um_pkg::OP_LDVAL:
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = item_reg.instr_word[um_pkg::LV_REG_LSB +: IW];
                            ram_wdata = W'(item_reg.instr_word[um_pkg::LV_REG_LSB-1:0]);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            um_pkg::S_ALU:
            begin
                if (alu_stat.done)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = fa;
                    ram_wdata  = alu_result;
                    state_next = um_pkg::S_DONE;
                end
            end
            um_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = um_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = um_pkg::S_IDLE;
            end
        endcase

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= um_pkg::S_IDLE;
            out_valid_reg  <= 1'b0;
            valid_reg      <= '0;
            pend_dest_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            valid_reg      <= valid_next;
            pend_dest_reg  <= pend_dest_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        vb_reg   <= vb_next;
        vc_reg   <= vc_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign in_ready  = (state_reg == um_pkg::S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `ASSERT_IMP(a_done_in_alu, clk, rst_n, alu_stat.done, state_reg == um_pkg::S_ALU)
    `ASSERT_IMP(a_write_when_exec, clk, rst_n, ram_we, state_reg == um_pkg::S_EXEC || state_reg == um_pkg::S_ALU)
    `ASSERT_IMP(a_pend_from_exec, clk, rst_n, $rose(pend_valid_reg), $past(state_reg) == um_pkg::S_EXEC)
    `ASSERT_IMP(a_alu_idle_outside, clk, rst_n, alu_stat.busy, state_reg == um_pkg::S_ALU)

endmodule

@@ bench/tb_um_instruction_execute.sv @@
// ----------------------------------------------------------------------------
// tb_um_instruction_execute
// Self-checking bench for the register machine execute unit. Directed
// instruction sequences cover each opcode and corner case. Random programs
// with load/map responses follow. A mirror of the register file and of the
// pending response predicts every transaction, and each output transaction
// is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_um_instruction_execute;

    import um_pkg::*;

    localparam logic REQ_INSTR = 1'b0;
    localparam logic REQ_RESP  = 1'b1;
    localparam logic [OPCODE_W-1:0] OP_NOP_LO = 4'd14;
    localparam logic [OPCODE_W-1:0] OP_NOP_HI = 4'd15;
    localparam logic [DATA_W-1:0] LDVAL_MASK =
        {{(DATA_W-LV_REG_LSB){1'b0}}, {LV_REG_LSB{1'b1}}};
    localparam int RANDOM_ITEMS = 1400;
    localparam int CALM_TAIL    = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 500000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_t  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    // mirror of the unit state
    logic [DATA_W-1:0]    regs [REG_CNT];
    logic [REG_IDX_W-1:0] resp_dest;
    logic                 awaiting_resp;

    out_t unit_out_q [$];
    int   mismatch_cnt = 0;
    int   cycle_cnt = 0;
    int   stall_left = 0;
    bit   idle_on = 1'b1;

    um_instruction_execute dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #5 clk = ~clk;

    // applies one transaction to the mirror and returns what the unit must emit
    function automatic out_t um_execute(input in_t item);
        out_t                 res;
        logic [DATA_W-1:0]    w;
        logic [REG_IDX_W-1:0] ra, rb, rc;
        logic [DATA_W-1:0]    vb, vc;
        w  = item.instr_word;
        ra = w[8:6];
        rb = w[5:3];
        rc = w[2:0];
        vb = regs[rb];
        vc = regs[rc];
        res = '0;
        if (item.req_type == REQ_RESP) begin
            if (awaiting_resp) begin
                regs[resp_dest] = item.resp_value;
                awaiting_resp = 1'b0;
            end
        end
        else begin
            case (w[OPCODE_LSB +: OPCODE_W])
                OP_CMOV:
                    if (vc != '0)
                        regs[ra] = vb;
                OP_LOAD:
                begin
                    res.action = ACT_LOAD;
                    res.segment_id = vb;
                    res.seg_offset = vc;
                    resp_dest = ra;
                    awaiting_resp = 1'b1;
                end
                OP_STORE:
                begin
                    res.action = ACT_STORE;
                    res.segment_id = regs[ra];
                    res.seg_offset = vb;
                    res.data_value = vc;
                end
                OP_ADD:
                    regs[ra] = vb + vc;
                OP_MUL:
                    regs[ra] = vb * vc;
                OP_DIV:
                    if (vc == '0)
                        res.fault = 1'b1;
                    else
                        regs[ra] = vb / vc;
                OP_NAND:
                    regs[ra] = ~(vb & vc);
                OP_HALT:
                    res.action = ACT_HALT;
                OP_MAP:
                begin
                    res.action = ACT_MAP;
                    res.data_value = vc;
                    resp_dest = rb;
                    awaiting_resp = 1'b1;
                end
                OP_UNMAP:
                begin
                    res.action = ACT_UNMAP;
                    res.segment_id = vc;
                end
                OP_OUT:
                begin
                    res.action = ACT_OUT;
                    res.out_char = vc[7:0];
                end
                OP_IN:
                    regs[rc] = item.in_eof ? ALL_ONES : {{(DATA_W-8){1'b0}}, item.in_byte};
                OP_LDPRG:
                begin
                    res.action = ACT_LDPRG;
                    res.segment_id = vb;
                    res.jump_valid = 1'b1;
                    res.jump_target = vc;
                end
                OP_LDVAL:
                    regs[w[LV_REG_LSB +: REG_IDX_W]] = w & LDVAL_MASK;
                default:
                    ;
            endcase
        end
        return res;
    endfunction

    function automatic in_t instr(input logic [OPCODE_W-1:0] op,
                                  input logic [REG_IDX_W-1:0] ra, rb, rc);
        in_t item;
        item = '0;
        item.req_type = REQ_INSTR;
        item.instr_word[OPCODE_LSB +: OPCODE_W] = op;
        item.instr_word[8:0] = {ra, rb, rc};
        return item;
    endfunction

    function automatic in_t ldval(input logic [REG_IDX_W-1:0] rd,
                                  input logic [DATA_W-1:0] value);
        in_t item;
        item = instr(OP_LDVAL, '0, '0, '0);
        item.instr_word[LV_REG_LSB +: REG_IDX_W] = rd;
        item.instr_word[LV_REG_LSB-1:0] = value[LV_REG_LSB-1:0];
        return item;
    endfunction

    function automatic in_t mem_resp(input logic [DATA_W-1:0] value);
        in_t item;
        item = '0;
        item.req_type = REQ_RESP;
        item.resp_value = value;
        return item;
    endfunction

    // every field random, the caller fixes what it needs
    function automatic in_t rand_item(input logic kind);
        in_t item;
        item.req_type   = kind;
        item.instr_word = $urandom;
        item.in_byte    = 8'($urandom);
        item.in_eof     = ($urandom_range(0, 3) == 0);
        item.resp_value = $urandom;
        return item;
    endfunction

    // valid stays high across back-to-back transactions
    task automatic send_item(input in_t item);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        unit_out_q.push_back(um_execute(item));
    endtask

    task automatic test_arith();
        send_item(ldval(3'd1, LDVAL_MASK));
        send_item(ldval(3'd2, 32'd7));
        send_item(instr(OP_ADD, 3'd3, 3'd1, 3'd1));
        send_item(instr(OP_MUL, 3'd4, 3'd1, 3'd1));
        send_item(instr(OP_DIV, 3'd5, 3'd4, 3'd2));
        // divide by zero leaves r5 alone
        send_item(instr(OP_DIV, 3'd5, 3'd1, 3'd0));
        send_item(instr(OP_NAND, 3'd6, 3'd1, 3'd2));
        send_item(instr(OP_CMOV, 3'd7, 3'd1, 3'd0));
        send_item(instr(OP_CMOV, 3'd7, 3'd1, 3'd2));
    endtask

    task automatic test_io();
        in_t item;
        item = instr(OP_IN, '0, '0, 3'd0);
        item.in_eof = 1'b1;
        send_item(item);
        item = instr(OP_IN, '0, '0, 3'd6);
        item.in_byte = 8'hA5;
        send_item(item);
        // wide value, only the low byte goes out
        send_item(instr(OP_OUT, '0, '0, 3'd0));
        send_item(instr(OP_ADD, 3'd3, 3'd0, 3'd2));
    endtask

    task automatic test_memory();
        send_item(instr(OP_LOAD, 3'd5, 3'd1, 3'd2));
        // store and map while the load is still outstanding
        send_item(instr(OP_STORE, 3'd3, 3'd4, 3'd6));
        send_item(instr(OP_MAP, '0, 3'd7, 3'd2));
        send_item(mem_resp(ALL_ONES));
        // nothing outstanding, ignored
        send_item(mem_resp(32'h1234_5678));
        send_item(instr(OP_UNMAP, '0, '0, 3'd7));
        send_item(ldval(3'd4, '0));
        send_item(instr(OP_LDPRG, '0, 3'd4, 3'd1));
    endtask

    task automatic test_special();
        send_item(instr(OP_HALT, 3'd1, 3'd2, 3'd3));
        send_item(instr(OP_NOP_LO, 3'd1, 3'd2, 3'd3));
        send_item(instr(OP_NOP_HI, 3'd7, 3'd7, 3'd7));
        send_item(instr(OP_LDPRG, '0, 3'd1, 3'd2));
    endtask

    task automatic test_random_program(input int n_items);
        int                  done_cnt;
        int                  pick;
        in_t                 item;
        logic [OPCODE_W-1:0] op;
        done_cnt = 0;
        while (done_cnt < n_items) begin
            if (done_cnt >= n_items - CALM_TAIL)
                idle_on = 1'b0;
            pick = $urandom_range(0, 99);
            if (awaiting_resp && pick < 40) begin
                item = rand_item(REQ_RESP);
                done_cnt++;
            end
            else if (!awaiting_resp && pick < 4) begin
                // stray response, does not count
                item = rand_item(REQ_RESP);
            end
            else begin
                item = rand_item(REQ_INSTR);
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    op = OP_LDVAL;
                else if (pick < 23)
                    op = OPCODE_W'($urandom_range(OP_NOP_LO, OP_NOP_HI));
                else if (pick < 25)
                    op = OP_HALT;
                else if (pick < 32)
                    op = OP_IN;
                else
                    op = OPCODE_W'($urandom_range(OP_CMOV, OP_LDPRG));
                item.instr_word[OPCODE_LSB +: OPCODE_W] = op;
                // seed some zero and boundary register values
                if (op == OP_LDVAL && $urandom_range(0, 5) == 0) begin
                    case ($urandom_range(0, 2))
                        0: item.instr_word &= ~LDVAL_MASK;
                        1: item.instr_word = (item.instr_word & ~LDVAL_MASK) | 32'd1;
                        default: item.instr_word |= LDVAL_MASK;
                    endcase
                end
                done_cnt++;
            end
            send_item(item);
        end
    endtask

    task automatic field_check(input string name, input logic [DATA_W-1:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_cnt++;
        end
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (unit_out_q.size() == 0) begin
            $error("unexpected transaction: action %0d", got.action);
            mismatch_cnt++;
            return;
        end
        want = unit_out_q.pop_front();
        field_check("action", DATA_W'(want.action), DATA_W'(got.action));
        field_check("segment_id", want.segment_id, got.segment_id);
        field_check("seg_offset", want.seg_offset, got.seg_offset);
        field_check("data_value", want.data_value, got.data_value);
        field_check("out_char", DATA_W'(want.out_char), DATA_W'(got.out_char));
        field_check("jump_valid", DATA_W'(want.jump_valid), DATA_W'(got.jump_valid));
        field_check("jump_target", want.jump_target, got.jump_target);
        field_check("fault", DATA_W'(want.fault), DATA_W'(got.fault));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_result(out_data);
    end

    // output back-pressure in bursts of random length
    always @(posedge clk)
    begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 4);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("tb_um_instruction_execute NOT OK");
        $finish;
    end

    initial
    begin
        foreach (regs[i])
            regs[i] = '0;
        resp_dest = '0;
        awaiting_resp = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_arith();
        test_io();
        test_memory();
        test_special();
        test_random_program(RANDOM_ITEMS);

        in_valid <= 1'b0;
        while (unit_out_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("tb_um_instruction_execute OK");
        else
            $display("tb_um_instruction_execute NOT OK");
        $finish;
    end

endmodule
